// ----- design/cst_pkg.sv -----
// Shared types, codes and character tables for the C subset tokenizer.
package cst_pkg;

  localparam int KEYWORD_PREFIX_CHARS_DEF = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  // token kinds
  localparam logic [3:0] KIND_LBRACE  = 4'd0;
  localparam logic [3:0] KIND_RBRACE  = 4'd1;
  localparam logic [3:0] KIND_LPAREN  = 4'd2;
  localparam logic [3:0] KIND_RPAREN  = 4'd3;
  localparam logic [3:0] KIND_SEMI    = 4'd4;
  localparam logic [3:0] KIND_OP      = 4'd5;
  localparam logic [3:0] KIND_KEYWORD = 4'd6;
  localparam logic [3:0] KIND_IDENT   = 4'd7;
  localparam logic [3:0] KIND_INT     = 4'd8;
  localparam logic [3:0] KIND_UNKNOWN = 4'd9;

  // operator codes
  localparam logic [4:0] OP_MINUS  = 5'd0;
  localparam logic [4:0] OP_TILDE  = 5'd1;
  localparam logic [4:0] OP_PLUS   = 5'd2;
  localparam logic [4:0] OP_STAR   = 5'd3;
  localparam logic [4:0] OP_SLASH  = 5'd4;
  localparam logic [4:0] OP_COLON  = 5'd5;
  localparam logic [4:0] OP_QUEST  = 5'd6;
  localparam logic [4:0] OP_COMMA  = 5'd7;
  localparam logic [4:0] OP_LAND   = 5'd8;
  localparam logic [4:0] OP_AMP    = 5'd9;
  localparam logic [4:0] OP_LOR    = 5'd10;
  localparam logic [4:0] OP_PIPE   = 5'd11;
  localparam logic [4:0] OP_LE     = 5'd12;
  localparam logic [4:0] OP_LT     = 5'd13;
  localparam logic [4:0] OP_GE     = 5'd14;
  localparam logic [4:0] OP_GT     = 5'd15;
  localparam logic [4:0] OP_NE     = 5'd16;
  localparam logic [4:0] OP_BANG   = 5'd17;
  localparam logic [4:0] OP_EQ     = 5'd18;
  localparam logic [4:0] OP_ASSIGN = 5'd19;

  // keyword codes
  localparam logic [3:0] KW_INT      = 4'd0;
  localparam logic [3:0] KW_RETURN   = 4'd1;
  localparam logic [3:0] KW_IF       = 4'd2;
  localparam logic [3:0] KW_ELSE     = 4'd3;
  localparam logic [3:0] KW_FOR      = 4'd4;
  localparam logic [3:0] KW_WHILE    = 4'd5;
  localparam logic [3:0] KW_DO       = 4'd6;
  localparam logic [3:0] KW_BREAK    = 4'd7;
  localparam logic [3:0] KW_CONTINUE = 4'd8;
  localparam logic [3:0] KW_NONE     = 4'd9;

  // pending first character of a two-character operator
  localparam logic [2:0] PEND_NONE = 3'd0;
  localparam logic [2:0] PEND_AMP  = 3'd1;
  localparam logic [2:0] PEND_PIPE = 3'd2;
  localparam logic [2:0] PEND_LT   = 3'd3;
  localparam logic [2:0] PEND_GT   = 3'd4;
  localparam logic [2:0] PEND_BANG = 3'd5;
  localparam logic [2:0] PEND_EQ   = 3'd6;

  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_OP   = 4'b0010,
    MODE_WORD = 4'b0100,
    MODE_NUM  = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [4:0]  op;
    logic [3:0]  kw;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic [7:0] pair_second(input logic [2:0] p);
    case (p)
      PEND_AMP:  return 8'h26;
      PEND_PIPE: return 8'h7C;
      PEND_LT, PEND_GT, PEND_BANG, PEND_EQ: return 8'h3D;
      default:   return 8'h00;
    endcase
  endfunction

  function automatic logic [4:0] pair_code(input logic [2:0] p);
    case (p)
      PEND_AMP:  return OP_LAND;
      PEND_PIPE: return OP_LOR;
      PEND_LT:   return OP_LE;
      PEND_GT:   return OP_GE;
      PEND_BANG: return OP_NE;
      PEND_EQ:   return OP_EQ;
      default:   return OP_MINUS;
    endcase
  endfunction

  function automatic logic [4:0] single_code(input logic [2:0] p);
    case (p)
      PEND_AMP:  return OP_AMP;
      PEND_PIPE: return OP_PIPE;
      PEND_LT:   return OP_LT;
      PEND_GT:   return OP_GT;
      PEND_BANG: return OP_BANG;
      PEND_EQ:   return OP_ASSIGN;
      default:   return OP_MINUS;
    endcase
  endfunction

  // Prefix bytes past the word length are zero, so a full 64-bit compare
  // plus the exact length identifies a keyword. Byte 0 sits in bits 7:0.
  function automatic logic [3:0] kw_lookup(input logic [63:0] pre, input logic [15:0] len);
    if (len == 16'd3 && pre == 64'h0000_0000_0074_6E69) return KW_INT;
    if (len == 16'd6 && pre == 64'h0000_6E72_7574_6572) return KW_RETURN;
    if (len == 16'd2 && pre == 64'h0000_0000_0000_6669) return KW_IF;
    if (len == 16'd4 && pre == 64'h0000_0000_6573_6C65) return KW_ELSE;
    if (len == 16'd3 && pre == 64'h0000_0000_0072_6F66) return KW_FOR;
    if (len == 16'd5 && pre == 64'h0000_0065_6C69_6877) return KW_WHILE;
    if (len == 16'd2 && pre == 64'h0000_0000_0000_6F64) return KW_DO;
    if (len == 16'd5 && pre == 64'h0000_006B_6165_7262) return KW_BREAK;
    if (len == 16'd8 && pre == 64'h6575_6E69_746E_6F63) return KW_CONTINUE;
    return KW_NONE;
  endfunction

endpackage

// ----- design/c_subset_tokenizer.sv -----
// Streaming tokenizer for a small C subset, one source byte per transfer.
//
// Each input transfer carries one source byte, or an end mark (end_mark = 1)
// that flushes the pending token without consuming a byte position. The
// scanner state (mode, pending operator character, keyword prefix, run
// length, token start and byte position) updates in the same cycle a byte
// is accepted, and the tokens it causes (none, one or two) are written into
// a four-entry result queue that drives the output ports directly. A byte
// that closes a pending word, number or operator and also starts a token of
// its own gives two tokens; last_of_run marks the final token of a transfer.
// Throughput: one byte per cycle as long as the consumer takes one token per
// cycle; char_ready is high while the queue has room for two tokens, so a
// stretch of two-token bytes is slowed by the single output port. A token can
// leave in the cycle after the byte that completes it. Words are matched
// against nine keywords using their first KEYWORD_PREFIX_CHARS characters and
// exact length; lengths saturate at 65535 and start offsets wrap at 2^32. No
// clearing pass after reset.
module c_subset_tokenizer #(
  parameter int KEYWORD_PREFIX_CHARS = cst_pkg::KEYWORD_PREFIX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  char_code,
  input  logic        end_mark,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [3:0]  token_kind,
  output logic [4:0]  operator_code,
  output logic [3:0]  keyword_code,
  output logic [31:0] start_offset,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  localparam int IW = $clog2(KEYWORD_PREFIX_CHARS);
  localparam int CW = cst_pkg::FIFO_AW + 1;

  // Scanner state
  cst_pkg::scan_mode_t scan_mode, scan_mode_next;
  logic [2:0]          pend_char, pend_char_next;
  logic [KEYWORD_PREFIX_CHARS-1:0][7:0] prefix, prefix_next;
  logic [15:0]         cur_len, cur_len_next;
  logic [31:0]         token_start, token_start_next;
  logic [31:0]         byte_pos, byte_pos_next;

  // Result queue
  cst_pkg::token_t     fifo [cst_pkg::FIFO_DEPTH];
  logic [cst_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0]       count;

  logic                accept, pop;
  logic                tok_a_v, tok_b_v;
  cst_pkg::token_t     tok_a, tok_b, flush_tok;
  logic                consumed;
  logic [3:0]          kw;
  logic [1:0]          n_push;

  assign accept = char_valid & char_ready;
  assign pop    = token_valid & token_ready;

  // Room for two tokens keeps the worst case of one byte safe.
  assign char_ready  = (count <= CW'(cst_pkg::FIFO_DEPTH - 2));
  assign token_valid = (count != '0);

  // Token that the pending run would give if it ended now.
  always_comb begin
    kw = cst_pkg::kw_lookup(prefix[7:0], cur_len);
    flush_tok = '0;
    flush_tok.kw    = cst_pkg::KW_NONE;
    flush_tok.start = token_start;
    flush_tok.len   = cur_len;
    case (scan_mode)
      cst_pkg::MODE_OP: begin
        flush_tok.kind = cst_pkg::KIND_OP;
        flush_tok.op   = cst_pkg::single_code(pend_char);
        flush_tok.len  = 16'd1;
      end
      cst_pkg::MODE_WORD: begin
        flush_tok.kind = (kw == cst_pkg::KW_NONE) ? cst_pkg::KIND_IDENT
                                                  : cst_pkg::KIND_KEYWORD;
        flush_tok.kw   = kw;
      end
      cst_pkg::MODE_NUM: begin
        flush_tok.kind = cst_pkg::KIND_INT;
      end
      default: begin
        flush_tok.kind = cst_pkg::KIND_LBRACE;
      end
    endcase
  end

  // Next scanner state and the tokens caused by this byte. Token A closes
  // the pending run; token B comes from handling the byte from idle.
  always_comb begin
    scan_mode_next   = scan_mode;
    pend_char_next   = pend_char;
    prefix_next      = prefix;
    cur_len_next     = cur_len;
    token_start_next = token_start;
    byte_pos_next    = byte_pos;
    consumed         = 1'b0;
    tok_a_v          = 1'b0;
    tok_b_v          = 1'b0;
    tok_a            = flush_tok;
    tok_b            = '0;
    tok_b.kw         = cst_pkg::KW_NONE;
    tok_b.start      = byte_pos;
    tok_b.len        = 16'd1;

    if (end_mark) begin
      // Flush and go idle; the byte position holds.
      tok_a_v        = (scan_mode != cst_pkg::MODE_IDLE);
      scan_mode_next = cst_pkg::MODE_IDLE;
      pend_char_next = cst_pkg::PEND_NONE;
    end else begin
      byte_pos_next = byte_pos + 32'd1;

      case (scan_mode)
        cst_pkg::MODE_OP: begin
          if (pend_char != cst_pkg::PEND_NONE &&
              char_code == cst_pkg::pair_second(pend_char)) begin
            tok_a_v        = 1'b1;
            tok_a.op       = cst_pkg::pair_code(pend_char);
            tok_a.len      = 16'd2;
            scan_mode_next = cst_pkg::MODE_IDLE;
            pend_char_next = cst_pkg::PEND_NONE;
            consumed       = 1'b1;
          end
        end
        cst_pkg::MODE_WORD, cst_pkg::MODE_NUM: begin
          if (cst_pkg::is_letter(char_code) || cst_pkg::is_digit(char_code) ||
              (scan_mode == cst_pkg::MODE_WORD &&
               char_code == cst_pkg::CHAR_UNDERSCORE)) begin
            consumed = 1'b1;
            if (cur_len < 16'(KEYWORD_PREFIX_CHARS)) begin
              prefix_next[cur_len[IW-1:0]] = char_code;
            end
            if (cur_len != 16'hFFFF) begin
              cur_len_next = cur_len + 16'd1;
            end
          end
        end
        default: begin
        end
      endcase

      if (!consumed) begin
        // Close the pending run, then take the byte from idle.
        tok_a_v        = (scan_mode != cst_pkg::MODE_IDLE);
        scan_mode_next = cst_pkg::MODE_IDLE;
        pend_char_next = cst_pkg::PEND_NONE;

        tok_b_v   = 1'b1;
        tok_b.kind = cst_pkg::KIND_OP;
        case (char_code)
          8'h20, 8'h0A, 8'h0D: tok_b_v = 1'b0;
          8'h7B: tok_b.kind = cst_pkg::KIND_LBRACE;
          8'h7D: tok_b.kind = cst_pkg::KIND_RBRACE;
          8'h28: tok_b.kind = cst_pkg::KIND_LPAREN;
          8'h29: tok_b.kind = cst_pkg::KIND_RPAREN;
          8'h3B: tok_b.kind = cst_pkg::KIND_SEMI;
          8'h2D: tok_b.op = cst_pkg::OP_MINUS;
          8'h7E: tok_b.op = cst_pkg::OP_TILDE;
          8'h2B: tok_b.op = cst_pkg::OP_PLUS;
          8'h2A: tok_b.op = cst_pkg::OP_STAR;
          8'h2F: tok_b.op = cst_pkg::OP_SLASH;
          8'h3A: tok_b.op = cst_pkg::OP_COLON;
          8'h3F: tok_b.op = cst_pkg::OP_QUEST;
          8'h2C: tok_b.op = cst_pkg::OP_COMMA;
          8'h26, 8'h7C, 8'h3C, 8'h3E, 8'h21, 8'h3D: begin
            // First character of a possible pair: hold it for one byte.
            tok_b_v          = 1'b0;
            scan_mode_next   = cst_pkg::MODE_OP;
            token_start_next = byte_pos;
            case (char_code)
              8'h26:   pend_char_next = cst_pkg::PEND_AMP;
              8'h7C:   pend_char_next = cst_pkg::PEND_PIPE;
              8'h3C:   pend_char_next = cst_pkg::PEND_LT;
              8'h3E:   pend_char_next = cst_pkg::PEND_GT;
              8'h21:   pend_char_next = cst_pkg::PEND_BANG;
              default: pend_char_next = cst_pkg::PEND_EQ;
            endcase
          end
          default: begin
            if (cst_pkg::is_letter(char_code) || cst_pkg::is_digit(char_code)) begin
              // Start a word or a number run.
              tok_b_v          = 1'b0;
              scan_mode_next   = cst_pkg::is_letter(char_code) ? cst_pkg::MODE_WORD
                                                               : cst_pkg::MODE_NUM;
              token_start_next = byte_pos;
              cur_len_next     = 16'd1;
              prefix_next      = '0;
              prefix_next[0]   = char_code;
            end else begin
              tok_b.kind = cst_pkg::KIND_UNKNOWN;
            end
          end
        endcase
      end
    end

    tok_a.last = ~tok_b_v;
    tok_b.last = 1'b1;
  end

  assign n_push = accept ? ({1'b0, tok_a_v} + {1'b0, tok_b_v}) : 2'd0;

  // Scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= cst_pkg::MODE_IDLE;
      pend_char   <= cst_pkg::PEND_NONE;
      prefix      <= '0;
      cur_len     <= '0;
      token_start <= '0;
      byte_pos    <= '0;
    end else if (accept) begin
      scan_mode   <= scan_mode_next;
      pend_char   <= pend_char_next;
      prefix      <= prefix_next;
      cur_len     <= cur_len_next;
      token_start <= token_start_next;
      byte_pos    <= byte_pos_next;
    end
  end

  // Result queue payload: write A, then B behind it.
  always_ff @(posedge clk) begin
    if (accept && tok_a_v) begin
      fifo[wr_ptr] <= tok_a;
    end
    if (accept && tok_b_v) begin
      fifo[wr_ptr + cst_pkg::FIFO_AW'(tok_a_v)] <= tok_b;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + cst_pkg::FIFO_AW'(n_push);
      rd_ptr <= rd_ptr + cst_pkg::FIFO_AW'(pop);
      count  <= count + CW'(n_push) - CW'(pop);
    end
  end

  assign token_kind    = fifo[rd_ptr].kind;
  assign operator_code = fifo[rd_ptr].op;
  assign keyword_code  = fifo[rd_ptr].kw;
  assign start_offset  = fifo[rd_ptr].start;
  assign token_length  = fifo[rd_ptr].len;
  assign last_of_run   = fifo[rd_ptr].last;

endmodule
